/* src/hvn_pkg.sv */
`timescale 1ns / 1ps
package hvn_pkg;

	localparam int MAX_DIM_DEF = 1024;

	// field widths
	localparam int H_W    = 16;
	localparam int NRM_W  = 16;
	localparam int POS_W  = 10;
	localparam int CFG_W  = 11;
	localparam int ACC_W  = 19;
	localparam int DIN_W  = 16;
	localparam int DOUT_W = 72;

	// unit length in Q1.14
	localparam logic [NRM_W-1:0] Q14_ONE = 16'd16384;
	// face y component in Q8.8
	localparam logic signed [ACC_W-1:0] FACE_Y = 19'sd256;

	// configuration register indexes
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		T_IDLE,
		T_RD,
		T_WR,
		T_FACE,
		T_NORM,
		T_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SQ,
		N_ROOT,
		N_DLD,
		N_DIV,
		N_DONE
	} norm_state_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ACC_W-1:0] z;
	} acc_vec_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
	} nrm_vec_t;

	function automatic logic signed [ACC_W-1:0] ext_h(input logic signed [H_W-1:0] v);
		return {{(ACC_W-H_W){v[H_W-1]}}, v};
	endfunction

endpackage

/* src/hvn_norm.sv */
`timescale 1ns / 1ps
module hvn_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hvn_pkg::acc_vec_t vec,
	output logic              done,
	output hvn_pkg::nrm_vec_t nrm
);
	import hvn_pkg::*;

	localparam int MAG_W  = ACC_W - 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int QS_W   = SQ_W + 2;
	localparam int X_W    = 63;
	localparam int D_W    = 31;
	localparam int NUM_W  = MAG_W + 27;
	localparam int DV_W   = D_W + 16;
	localparam int QUO_W  = 16;

	norm_state_t state_q, state_nx;

	logic signed [ACC_W-1:0] s_q [3];
	logic [1:0]              k_q;
	logic [SQ_W-1:0]         prod_q;
	logic [QS_W-1:0]         qsum_q;
	logic [X_W-1:0]          x_q, res_q, bit_q;
	logic [DV_W-1:0]         rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic [3:0]              i_q;
	logic                    sat_q;
	logic signed [NRM_W-1:0] nrm_q [3];

	logic [MAG_W-1:0]        mag_k, mag_j;
	logic [QS_W-1:0]         qsum_nx;
	logic [X_W-1:0]          trial;
	logic [D_W-1:0]          den;
	logic [NUM_W-1:0]        num;
	logic [DV_W-1:0]         dsh;
	logic [QUO_W-1:0]        quo_nx, lim;
	logic signed [NRM_W-1:0] signed_lim;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] n;
		n = -v;
		return v[ACC_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	// operand selection and datapath
	always_comb begin
		mag_k   = mag_of(s_q[k_q]);
		mag_j   = mag_of(s_q[k_q]);
		qsum_nx = qsum_q + QS_W'(prod_q);
		trial   = res_q + bit_q;
		den     = res_q[D_W-1:0];
		num     = {1'b0, mag_j, 26'b0} + NUM_W'(den >> 1);
		dsh     = DV_W'(den) << i_q;
		quo_nx  = quo_q;
		if (rem_q >= dsh)
			quo_nx[i_q] = 1'b1;
		lim = (sat_q || quo_nx > Q14_ONE) ? Q14_ONE : quo_nx;
		signed_lim = s_q[k_q][ACC_W-1] ? -signed'(lim) : signed'(lim);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		done     = 1'b0;
		case (state_q)
			N_IDLE: begin
				if (start)
					state_nx = N_SQ;
			end
			N_SQ: begin
				if (k_q == 2'd3)
					state_nx = N_ROOT;
			end
			N_ROOT: begin
				if (bit_q[0])
					state_nx = N_DLD;
			end
			N_DLD: state_nx = N_DIV;
			N_DIV: begin
				if (i_q == 4'd0)
					state_nx = (k_q == 2'd2) ? N_DONE : N_DLD;
			end
			N_DONE: begin
				done     = 1'b1;
				state_nx = N_IDLE;
			end
			default: state_nx = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= N_IDLE;
		else
			state_q <= state_nx;
	end

	// square, root and divide registers
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					s_q[0] <= vec.x;
					s_q[1] <= vec.y;
					s_q[2] <= vec.z;
					k_q    <= 2'd0;
					qsum_q <= '0;
				end
			end
			N_SQ: begin
				prod_q <= mag_k * mag_k;
				if (k_q != 2'd0)
					qsum_q <= qsum_nx;
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					x_q   <= X_W'({qsum_nx, 24'b0});
					res_q <= '0;
					bit_q <= X_W'(1) << 62;
					k_q   <= 2'd0;
				end
			end
			N_ROOT: begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DLD: begin
				rem_q <= DV_W'(num);
				sat_q <= DV_W'(num) >= {den, 16'b0};
				quo_q <= '0;
				i_q   <= 4'd15;
			end
			N_DIV: begin
				if (rem_q >= dsh)
					rem_q <= rem_q - dsh;
				quo_q <= quo_nx;
				i_q   <= i_q - 4'd1;
				if (i_q == 4'd0) begin
					nrm_q[k_q] <= signed_lim;
					k_q        <= k_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign nrm.x = nrm_q[0];
	assign nrm.y = nrm_q[1];
	assign nrm.z = nrm_q[2];

endmodule

/* src/heightmap_vertex_normals.sv */
`timescale 1ns / 1ps
// One height sample at a time: the two row buffers are read and the sample is written,
// then each emitted normal passes through the shared root and divide unit (32 root steps,
// then a divider load and a bit-serial divide per component); an item emits 0, 1 or 2 normals.
// The output register lets the next sample in while a normal still waits to be taken.
// Reset clears the position counters and window and sets both grid sizes to 256;
// the row buffer memory is not cleared.
module heightmap_vertex_normals #(
	parameter int MAX_DIM = hvn_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [hvn_pkg::DIN_W-1:0]    s_tdata,   // height[15:0]
	input  logic                         s_tuser,   // frame_start
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hvn_pkg::DOUT_W-1:0]   m_tdata,   // normal_x, normal_y, normal_z,
	                                                // vertex_col, vertex_row, zero pad
	output logic                         m_tlast,   // run_last
	output logic                         m_tuser,   // frame_end
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [hvn_pkg::CFG_W-1:0]    cfg_data
);
	import hvn_pkg::*;

	localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int LW = (DW > CFG_W) ? DW : CFG_W;
	localparam int AW = $clog2(2 * MAX_DIM);

	top_state_t state_q, state_nx;

	logic [CFG_W-1:0] grid_width_q, grid_height_q;
	logic [CW-1:0]    col_cnt_q, row_cnt_q;
	logic [CW-1:0]    c_q, r_q;
	logic [H_W-1:0]   hv_q;
	logic [2:0]       rd_q;
	logic             vert_b_q;
	logic [H_W-1:0]   nb_q [4];
	logic [H_W-1:0]   win_q [6];
	logic [H_W-1:0]   row_store_q [2*MAX_DIM];
	logic [H_W-1:0]   rdat_q;

	logic [LW-1:0] w_raw, h_raw, w_lim, h_lim;
	logic [DW-1:0] w_dim, h_dim, c_inc, r_inc;
	logic          cl, cr, need_a, need_b, restart;
	logic [CW-1:0] cn;
	logic [AW-1:0] raddr, waddr;
	logic          accept, mem_we, load_out, adv, norm_start, norm_done, out_free;
	acc_vec_t      acc;
	nrm_vec_t      nrm;
	logic [CW-1:0] row_v;
	logic [CW+POS_W-1:0] col_ext, row_ext;

	function automatic logic [AW-1:0] row_addr(input logic p, input logic [CW-1:0] col);
		logic [AW:0] base;
		base = p ? (AW+1)'(MAX_DIM) : '0;
		return AW'(base + (AW+1)'(col));
	endfunction

	// clamp grid sizes and derive position flags
	always_comb begin
		w_raw = LW'(grid_width_q);
		h_raw = LW'(grid_height_q);
		if (w_raw < LW'(2))
			w_lim = LW'(2);
		else if (w_raw > LW'(MAX_DIM))
			w_lim = LW'(MAX_DIM);
		else
			w_lim = w_raw;
		if (h_raw < LW'(2))
			h_lim = LW'(2);
		else if (h_raw > LW'(MAX_DIM))
			h_lim = LW'(MAX_DIM);
		else
			h_lim = h_raw;
		w_dim   = w_lim[DW-1:0];
		h_dim   = h_lim[DW-1:0];
		c_inc   = DW'(c_q) + DW'(1);
		r_inc   = DW'(r_q) + DW'(1);
		cl      = c_q != '0;
		cr      = c_inc < w_dim;
		need_a  = r_q != '0;
		need_b  = r_inc == h_dim;
		cn      = cr ? c_inc[CW-1:0] : c_q;
		restart = s_tuser || DW'(col_cnt_q) >= w_dim || DW'(row_cnt_q) >= h_dim;
	end

	// row buffer addresses: rows r-2 and r-1 at columns c and c+1
	always_comb begin
		case (rd_q)
			3'd0:    raddr = row_addr(r_q[0], c_q);
			3'd1:    raddr = row_addr(~r_q[0], c_q);
			3'd2:    raddr = row_addr(r_q[0], cn);
			default: raddr = row_addr(~r_q[0], cn);
		endcase
		waddr = row_addr(r_q[0], c_q);
	end

	// face sums of the vertex being emitted
	always_comb begin
		logic signed [ACC_W-1:0] t0, t1, t2, m0, m1, m2, b0, b1;
		logic vt, vb;
		if (!vert_b_q) begin
			t0 = ext_h(win_q[0]); t1 = ext_h(win_q[1]); t2 = ext_h(nb_q[2]);
			m0 = ext_h(win_q[2]); m1 = ext_h(win_q[3]); m2 = ext_h(nb_q[3]);
			b0 = ext_h(win_q[4]); b1 = ext_h(win_q[5]);
			vt = DW'(r_q) >= DW'(2);
			vb = 1'b1;
		end else begin
			t0 = ext_h(win_q[2]); t1 = ext_h(win_q[3]); t2 = ext_h(nb_q[3]);
			m0 = ext_h(win_q[4]); m1 = ext_h(win_q[5]); m2 = '0;
			b0 = '0; b1 = '0;
			vt = 1'b1;
			vb = 1'b0;
		end
		acc = '0;
		if (cl && vt) begin
			acc.x = acc.x + t0 - t1; acc.y = acc.y + FACE_Y; acc.z = acc.z + t0 - m0;
		end
		if (cr && vt) begin
			acc.x = acc.x + t1 - t2; acc.y = acc.y + FACE_Y; acc.z = acc.z + t1 - m1;
		end
		if (cl && vb) begin
			acc.x = acc.x + m0 - m1; acc.y = acc.y + FACE_Y; acc.z = acc.z + m0 - b0;
		end
		if (cr && vb) begin
			acc.x = acc.x + m1 - m2; acc.y = acc.y + FACE_Y; acc.z = acc.z + m1 - b1;
		end
		row_v   = vert_b_q ? r_q : r_q - CW'(1);
		col_ext = {{POS_W{1'b0}}, c_q};
		row_ext = {{POS_W{1'b0}}, row_v};
	end

	hvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vec    (acc),
		.done   (norm_done),
		.nrm    (nrm)
	);

	assign s_tready  = state_q == T_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;

	// sequencer
	always_comb begin
		state_nx   = state_q;
		mem_we     = 1'b0;
		load_out   = 1'b0;
		adv        = 1'b0;
		norm_start = 1'b0;
		case (state_q)
			T_IDLE: begin
				if (s_tvalid)
					state_nx = T_RD;
			end
			T_RD: begin
				if (rd_q == 3'd4)
					state_nx = T_WR;
			end
			T_WR: begin
				mem_we = 1'b1;
				if (need_a || need_b) begin
					state_nx = T_FACE;
				end else begin
					adv      = 1'b1;
					state_nx = T_IDLE;
				end
			end
			T_FACE: begin
				norm_start = 1'b1;
				state_nx   = T_NORM;
			end
			T_NORM: begin
				if (norm_done)
					state_nx = T_OUT;
			end
			T_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (!vert_b_q && need_b) begin
						state_nx = T_FACE;
					end else begin
						adv      = 1'b1;
						state_nx = T_IDLE;
					end
				end
			end
			default: state_nx = T_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			grid_width_q  <= CFG_W'(256);
			grid_height_q <= CFG_W'(256);
			col_cnt_q     <= '0;
			row_cnt_q     <= '0;
			rd_q          <= '0;
			vert_b_q      <= 1'b0;
			m_tvalid      <= 1'b0;
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				if (cfg_index == REG_GRID_WIDTH)
					grid_width_q <= cfg_data;
				else
					grid_height_q <= cfg_data;
			end
			if (accept)
				rd_q <= '0;
			else if (state_q == T_RD)
				rd_q <= rd_q + 3'd1;
			if (state_q == T_WR) begin
				vert_b_q <= !need_a;
				win_q[0] <= win_q[1];
				win_q[2] <= win_q[3];
				win_q[4] <= win_q[5];
				win_q[1] <= nb_q[0];
				win_q[3] <= nb_q[1];
				win_q[5] <= hv_q;
			end else if (load_out) begin
				vert_b_q <= 1'b1;
			end
			if (adv) begin
				if (cr) begin
					col_cnt_q <= c_inc[CW-1:0];
					row_cnt_q <= r_q;
				end else begin
					col_cnt_q <= '0;
					row_cnt_q <= (r_inc >= h_dim) ? '0 : r_inc[CW-1:0];
				end
			end
			if (load_out)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	// request payload and neighbor heights
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q  <= restart ? '0 : col_cnt_q;
			r_q  <= restart ? '0 : row_cnt_q;
			hv_q <= s_tdata[H_W-1:0];
		end
		if (state_q == T_RD && rd_q != 3'd0)
			nb_q[2'(rd_q - 3'd1)] <= rdat_q;
		if (load_out) begin
			m_tdata <= {4'b0, row_ext[POS_W-1:0], col_ext[POS_W-1:0], nrm.z, nrm.y, nrm.x};
			m_tlast <= vert_b_q || !need_b;
			m_tuser <= vert_b_q && !cr;
		end
	end

	// row buffers, one read and one write port
	always_ff @(posedge clk) begin
		rdat_q <= row_store_q[raddr];
		if (mem_we)
			row_store_q[waddr] <= hv_q;
	end

endmodule
